// ===== src/threshold_graph_cluster_labeler_core_assert.svh =====
// assertion macros for the cluster labeler checker
`ifndef THRESHOLD_GRAPH_CLUSTER_LABELER_CORE_ASSERT_SVH
`define THRESHOLD_GRAPH_CLUSTER_LABELER_CORE_ASSERT_SVH

// same-cycle implication
`define TGCL_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TGCL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tgcl_pkg.sv =====
// shared constants, codes and types of the cluster labeler
`default_nettype none
package tgcl_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int COORD_BITS  = 12;

   localparam int IDX_BITS    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_POINTS + 1);
   localparam int OPD_BITS    = (COORD_BITS > 12) ? COORD_BITS : 12;
   localparam int SQ_BITS     = 2 * OPD_BITS;
   localparam int SUM_BITS    = SQ_BITS + 1;
   localparam int CMP_BITS    = (CNT_BITS > 7) ? CNT_BITS : 7;

   localparam int OP_BITS     = 2;
   localparam int FIELD_BITS  = 12;
   localparam int QIDX_BITS   = 6;
   localparam int ANS_BITS    = 7;
   localparam int JD_BITS     = 12;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_RUN   = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } tgcl_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUERY,
      ST_LIM1,
      ST_LIM2,
      ST_SCAN,
      ST_DEQ,
      ST_CURRD,
      ST_CURLD,
      ST_VSCAN,
      ST_DX,
      ST_DY,
      ST_CMP,
      ST_DONE
   } tgcl_state_type;

   typedef struct packed {
      logic sq_en;
      logic acc_en;
      logic lim_en;
   } tgcl_unit_ctl_type;

endpackage
`default_nettype wire

// ===== src/tgcl_req_if.sv =====
// request channel interface
`default_nettype none
interface tgcl_req_if;
   logic                            valid;
   logic                            ready;
   logic [tgcl_pkg::OP_BITS-1:0]    op;
   logic [tgcl_pkg::FIELD_BITS-1:0] point_x;
   logic [tgcl_pkg::FIELD_BITS-1:0] point_y;
   logic [tgcl_pkg::QIDX_BITS-1:0]  query_index;

   modport source (output valid, op, point_x, point_y, query_index, input ready);
   modport sink   (input valid, op, point_x, point_y, query_index, output ready);
endinterface
`default_nettype wire

// ===== src/tgcl_rsp_if.sv =====
// response channel interface
`default_nettype none
interface tgcl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tgcl_pkg::ANS_BITS-1:0] answer;
   logic                          error;

   modport source (output valid, answer, error, input ready);
   modport sink   (input valid, answer, error, output ready);
endinterface
`default_nettype wire

// ===== src/tgcl_csr_if.sv =====
// configuration write channel interface
`default_nettype none
interface tgcl_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tgcl_pkg::JD_BITS-1:0] join_distance;

   modport source (output valid, join_distance, input ready);
   modport sink   (input valid, join_distance, output ready);
endinterface
`default_nettype wire

// ===== src/tgcl_dist_unit.sv =====
// shared squarer with accumulate and limit compare
`default_nettype none
module tgcl_dist_unit (
   input  logic                          clock,
   input  tgcl_pkg::tgcl_unit_ctl_type   ctl,
   input  logic [tgcl_pkg::OPD_BITS-1:0] opd_a,
   input  logic [tgcl_pkg::OPD_BITS-1:0] opd_b,
   output logic                          linked
);
   localparam int OW = tgcl_pkg::OPD_BITS;
   localparam int SW = tgcl_pkg::SQ_BITS;
   localparam int UW = tgcl_pkg::SUM_BITS;

   logic [OW-1:0] diff;
   logic [SW-1:0] sq_in;
   logic [SW-1:0] sq_ff;
   logic [SW-1:0] acc_ff;
   logic [SW-1:0] lim_ff;
   logic [UW-1:0] sum;

   assign diff  = (opd_a > opd_b) ? (opd_a - opd_b) : (opd_b - opd_a);
   assign sq_in = SW'(diff) * SW'(diff);
   assign sum   = UW'(acc_ff) + UW'(sq_ff);
   assign linked = (sum <= UW'(lim_ff));

   always_ff @(posedge clock) begin
      if (ctl.sq_en) begin
         sq_ff <= sq_in;
      end
      if (ctl.acc_en) begin
         acc_ff <= sq_ff;
      end
      if (ctl.lim_en) begin
         lim_ff <= sq_ff;
      end
   end
endmodule
`default_nettype wire

// ===== src/threshold_graph_cluster_labeler_core.sv =====
// Cluster labeler top level: points are stored in on-chip memories and a small
// sequencer walks them with one shared squarer. A load or a clear is answered
// from the output register in the cycle after it is taken; a query passes
// through the query state before its answer is registered. A run squares the
// join distance into the limit register, then scans points for clusters and
// runs a pair distance test for each still-unlabeled candidate of each
// dequeued point, squaring dx and then dy, one square per cycle. The block
// takes no new item while a run or a query is in progress.
`default_nettype none
module threshold_graph_cluster_labeler_core (
   input  logic        clock,
   input  logic        reset,
   tgcl_req_if.sink    req_chan,
   tgcl_rsp_if.source  rsp_chan,
   tgcl_csr_if.sink    csr_chan
);
   localparam int MAXP = tgcl_pkg::MAX_POINTS;
   localparam int IW   = tgcl_pkg::IDX_BITS;
   localparam int CW   = tgcl_pkg::CNT_BITS;
   localparam int KW   = tgcl_pkg::COORD_BITS;
   localparam int OW   = tgcl_pkg::OPD_BITS;
   localparam int AW   = tgcl_pkg::ANS_BITS;
   localparam int MW   = tgcl_pkg::CMP_BITS;
   localparam int JW   = tgcl_pkg::JD_BITS;
   localparam int QW   = tgcl_pkg::QIDX_BITS;

   tgcl_pkg::tgcl_state_type    state_ff, state_in;
   tgcl_pkg::tgcl_op_type       op_in;
   tgcl_pkg::tgcl_unit_ctl_type unit_ctl;

   logic            req_fire, rsp_fire;
   logic [JW-1:0]   jd_ff;
   logic [CW-1:0]   pcount_ff, pcount_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [CW-1:0]   v_ff, v_in;
   logic [CW-1:0]   head_ff, head_in;
   logic [CW-1:0]   tail_ff, tail_in;
   logic [IW-1:0]   cur_ff, cur_in;
   logic [KW-1:0]   curx_ff, curx_in;
   logic [KW-1:0]   cury_ff, cury_in;
   logic [QW-1:0]   qi_ff, qi_in;
   logic [MAXP-1:0] valid_ff, valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]   answer_ff;
   logic            error_ff;

   logic [KW-1:0]   x_mem [MAXP];
   logic [KW-1:0]   y_mem [MAXP];
   logic [CW-1:0]   lab_mem [MAXP];
   logic [IW-1:0]   q_mem [MAXP];
   logic [KW-1:0]   x_rd_ff, y_rd_ff;
   logic [CW-1:0]   lab_rd_ff;
   logic [IW-1:0]   q_rd_ff;

   logic            xy_we, xy_re, lab_we, q_we, q_re;
   logic [IW-1:0]   xy_wa, xy_ra, lab_wa, lab_ra, q_wa, q_ra;
   logic [KW-1:0]   x_wd, y_wd;
   logic [CW-1:0]   lab_wd;
   logic [IW-1:0]   q_wd;
   logic [OW-1:0]   opd_a, opd_b;
   logic            linked;
   logic            rsp_set, rsp_err;
   logic [AW-1:0]   rsp_ans;

   logic            pc_full, scan_end, i_lab, q_empty, v_end, v_skip, q_err;
   logic [IW-1:0]   i_idx, v_idx, qi_idx;

   assign op_in    = tgcl_pkg::tgcl_op_type'(req_chan.op);
   assign req_chan.ready = (state_ff == tgcl_pkg::ST_IDLE) &&
                           (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.answer = answer_ff;
   assign rsp_chan.error  = error_ff;

   assign i_idx    = i_ff[IW-1:0];
   assign v_idx    = v_ff[IW-1:0];
   assign qi_idx   = IW'(qi_ff);
   assign pc_full  = (pcount_ff >= CW'(MAXP));
   assign scan_end = (i_ff >= pcount_ff);
   assign i_lab    = valid_ff[i_idx];
   assign q_empty  = (head_ff == tail_ff);
   assign v_end    = (v_ff >= pcount_ff);
   assign v_skip   = (v_idx == cur_ff) || valid_ff[v_idx];
   assign q_err    = (MW'(qi_ff) >= MW'(pcount_ff));
   assign lab_ra   = IW'(req_chan.query_index);

   tgcl_dist_unit u_dist (
      .clock  (clock),
      .ctl    (unit_ctl),
      .opd_a  (opd_a),
      .opd_b  (opd_b),
      .linked (linked)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tgcl_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (op_in)
                  tgcl_pkg::OP_RUN:   state_in = tgcl_pkg::ST_LIM1;
                  tgcl_pkg::OP_QUERY: state_in = tgcl_pkg::ST_QUERY;
                  default:            state_in = tgcl_pkg::ST_IDLE;
               endcase
            end
         end
         tgcl_pkg::ST_QUERY: state_in = tgcl_pkg::ST_IDLE;
         tgcl_pkg::ST_LIM1:  state_in = tgcl_pkg::ST_LIM2;
         tgcl_pkg::ST_LIM2:  state_in = tgcl_pkg::ST_SCAN;
         tgcl_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = tgcl_pkg::ST_DONE;
            end else if (!i_lab) begin
               state_in = tgcl_pkg::ST_DEQ;
            end
         end
         tgcl_pkg::ST_DEQ: begin
            state_in = q_empty ? tgcl_pkg::ST_SCAN : tgcl_pkg::ST_CURRD;
         end
         tgcl_pkg::ST_CURRD: state_in = tgcl_pkg::ST_CURLD;
         tgcl_pkg::ST_CURLD: state_in = tgcl_pkg::ST_VSCAN;
         tgcl_pkg::ST_VSCAN: begin
            if (v_end) begin
               state_in = tgcl_pkg::ST_DEQ;
            end else if (!v_skip) begin
               state_in = tgcl_pkg::ST_DX;
            end
         end
         tgcl_pkg::ST_DX:   state_in = tgcl_pkg::ST_DY;
         tgcl_pkg::ST_DY:   state_in = tgcl_pkg::ST_CMP;
         tgcl_pkg::ST_CMP:  state_in = tgcl_pkg::ST_VSCAN;
         tgcl_pkg::ST_DONE: state_in = tgcl_pkg::ST_IDLE;
         default:           state_in = tgcl_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      pcount_in = pcount_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      v_in      = v_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      cur_in    = cur_ff;
      curx_in   = curx_ff;
      cury_in   = cury_ff;
      qi_in     = qi_ff;
      valid_in  = valid_ff;
      xy_we     = 1'b0;
      xy_wa     = pcount_ff[IW-1:0];
      x_wd      = KW'(req_chan.point_x);
      y_wd      = KW'(req_chan.point_y);
      xy_re     = 1'b0;
      xy_ra     = v_idx;
      lab_we    = 1'b0;
      lab_wa    = v_idx;
      lab_wd    = count_ff;
      q_we      = 1'b0;
      q_wa      = tail_ff[IW-1:0];
      q_wd      = v_idx;
      q_re      = 1'b0;
      q_ra      = head_ff[IW-1:0];
      unit_ctl  = '0;
      opd_a     = OW'(curx_ff);
      opd_b     = OW'(x_rd_ff);
      rsp_set   = 1'b0;
      rsp_ans   = '0;
      rsp_err   = 1'b0;
      case (state_ff)
         tgcl_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (op_in)
                  tgcl_pkg::OP_LOAD: begin
                     rsp_set = 1'b1;
                     rsp_err = pc_full;
                     if (!pc_full) begin
                        xy_we = 1'b1;
                        valid_in[pcount_ff[IW-1:0]] = 1'b0;
                        pcount_in = pcount_ff + CW'(1);
                     end
                  end
                  tgcl_pkg::OP_RUN: begin
                     valid_in = '0;
                     count_in = '0;
                     i_in     = '0;
                  end
                  tgcl_pkg::OP_QUERY: begin
                     qi_in = req_chan.query_index;
                  end
                  tgcl_pkg::OP_CLEAR: begin
                     pcount_in = '0;
                     count_in  = '0;
                     valid_in  = '0;
                     rsp_set   = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         tgcl_pkg::ST_QUERY: begin
            rsp_set = 1'b1;
            rsp_err = q_err;
            if (!q_err && valid_ff[qi_idx]) begin
               rsp_ans = AW'(lab_rd_ff);
            end
         end
         tgcl_pkg::ST_LIM1: begin
            unit_ctl.sq_en = 1'b1;
            opd_a = OW'(jd_ff);
            opd_b = '0;
         end
         tgcl_pkg::ST_LIM2: begin
            unit_ctl.lim_en = 1'b1;
         end
         tgcl_pkg::ST_SCAN: begin
            if (!scan_end) begin
               if (i_lab) begin
                  i_in = i_ff + CW'(1);
               end else begin
                  count_in = count_ff + CW'(1);
                  lab_we   = 1'b1;
                  lab_wa   = i_idx;
                  lab_wd   = count_ff + CW'(1);
                  valid_in[i_idx] = 1'b1;
                  q_we     = 1'b1;
                  q_wa     = '0;
                  q_wd     = i_idx;
                  head_in  = '0;
                  tail_in  = CW'(1);
               end
            end
         end
         tgcl_pkg::ST_DEQ: begin
            if (q_empty) begin
               i_in = i_ff + CW'(1);
            end else begin
               q_re    = 1'b1;
               head_in = head_ff + CW'(1);
            end
         end
         tgcl_pkg::ST_CURRD: begin
            cur_in = q_rd_ff;
            xy_re  = 1'b1;
            xy_ra  = q_rd_ff;
         end
         tgcl_pkg::ST_CURLD: begin
            curx_in = x_rd_ff;
            cury_in = y_rd_ff;
            v_in    = '0;
         end
         tgcl_pkg::ST_VSCAN: begin
            if (!v_end) begin
               if (v_skip) begin
                  v_in = v_ff + CW'(1);
               end else begin
                  xy_re = 1'b1;
                  xy_ra = v_idx;
               end
            end
         end
         tgcl_pkg::ST_DX: begin
            unit_ctl.sq_en = 1'b1;
         end
         tgcl_pkg::ST_DY: begin
            unit_ctl.sq_en  = 1'b1;
            unit_ctl.acc_en = 1'b1;
            opd_a = OW'(cury_ff);
            opd_b = OW'(y_rd_ff);
         end
         tgcl_pkg::ST_CMP: begin
            if (linked) begin
               lab_we = 1'b1;
               lab_wa = v_idx;
               lab_wd = count_ff;
               valid_in[v_idx] = 1'b1;
               if (tail_ff < CW'(MAXP)) begin
                  q_we    = 1'b1;
                  q_wa    = tail_ff[IW-1:0];
                  q_wd    = v_idx;
                  tail_in = tail_ff + CW'(1);
               end
            end
            v_in = v_ff + CW'(1);
         end
         tgcl_pkg::ST_DONE: begin
            rsp_set = 1'b1;
            rsp_ans = AW'(count_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tgcl_pkg::ST_IDLE;
         jd_ff        <= '0;
         pcount_ff    <= '0;
         count_ff     <= '0;
         i_ff         <= '0;
         v_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         v_ff         <= v_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            jd_ff <= csr_chan.join_distance;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      curx_ff <= curx_in;
      cury_ff <= cury_in;
      qi_ff   <= qi_in;
      if (rsp_set) begin
         answer_ff <= rsp_ans;
         error_ff  <= rsp_err;
      end
   end

   // point coordinate memories
   always_ff @(posedge clock) begin
      if (xy_we) begin
         x_mem[xy_wa] <= x_wd;
         y_mem[xy_wa] <= y_wd;
      end
      if (xy_re) begin
         x_rd_ff <= x_mem[xy_ra];
         y_rd_ff <= y_mem[xy_ra];
      end
   end

   // label memory
   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_wa] <= lab_wd;
      end
      lab_rd_ff <= lab_mem[lab_ra];
   end

   // search queue memory
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_wa] <= q_wd;
      end
      if (q_re) begin
         q_rd_ff <= q_mem[q_ra];
      end
   end
endmodule
`default_nettype wire

// ===== src/tgcl_checker.sv =====
// port-level checker for the cluster labeler, bound to the top level
`default_nettype none
`include "threshold_graph_cluster_labeler_core_assert.svh"
module tgcl_checker (
   input logic        clock,
   input logic        reset,
   tgcl_req_if.sink   req_chan,
   tgcl_rsp_if.source rsp_chan,
   tgcl_csr_if.sink   csr_chan
);
   `TGCL_ASSERT_NOW(a_no_take_while_stalled, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "item taken while result stalled")
   `TGCL_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_chan.answer) && $stable(rsp_chan.error), "stalled result changed")
   `TGCL_ASSERT_NOW(a_error_zero_answer, clock, reset, rsp_chan.valid && rsp_chan.error, rsp_chan.answer == '0, "error result with nonzero answer")
   `TGCL_ASSERT_NEXT(a_load_answers, clock, reset, req_chan.valid && req_chan.ready && (req_chan.op == tgcl_pkg::OP_LOAD || req_chan.op == tgcl_pkg::OP_CLEAR), rsp_chan.valid, "load or clear not answered next cycle")
   `TGCL_ASSERT_NEXT(a_run_busy, clock, reset, req_chan.valid && req_chan.ready && req_chan.op == tgcl_pkg::OP_RUN, !req_chan.ready && csr_chan.ready, "new item taken during run")
endmodule

bind threshold_graph_cluster_labeler_core tgcl_checker u_tgcl_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan),
   .csr_chan (csr_chan)
);
`default_nettype wire

// ===== tb/threshold_graph_cluster_labeler_core_tb.sv =====
// self-checking testbench for the cluster labeler core: point sets, labeling runs and queries
module threshold_graph_cluster_labeler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tgcl_pkg::*;

   localparam int ITEM_TARGET = 1750;
   localparam int CALM_ITEMS  = 150;
   localparam int LONG_HOLD   = 250;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int JD_MAX      = (1 << JD_BITS) - 1;
   localparam int QIDX_MAX    = (1 << QIDX_BITS) - 1;

   typedef struct packed {
      tgcl_op_type             op;
      logic [FIELD_BITS-1:0]   point_x;
      logic [FIELD_BITS-1:0]   point_y;
      logic [QIDX_BITS-1:0]    query_index;
   } labeler_item_t;

   typedef struct packed {
      logic [ANS_BITS-1:0] answer;
      logic                error;
   } labeler_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tgcl_req_if req_bus ();
   tgcl_rsp_if rsp_bus ();
   tgcl_csr_if csr_bus ();

   threshold_graph_cluster_labeler_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #4 clock = ~clock;

   labeler_item_t   req_backlog [$];
   labeler_result_t rsp_expected [$];
   labeler_item_t   item_on_bus;

   int send_gap      = 0;
   int stall_left    = 0;
   int fail_count    = 0;
   int items_queued  = 0;
   bit steady_tail   = 1'b0;
   bit hold_rsp      = 1'b0;
   bit stall_request = 1'b0;

   // predictor state
   logic [COORD_BITS-1:0] x_mem     [MAX_POINTS];
   logic [COORD_BITS-1:0] y_mem     [MAX_POINTS];
   logic [ANS_BITS-1:0]   label_mem [MAX_POINTS];
   int                    point_total = 0;
   logic [JD_BITS-1:0]    join_distance_cfg = '0;

   function automatic bit in_reach(int a, int b);
      longint dx;
      longint dy;
      longint lim;
      dx  = longint'(x_mem[a]) - longint'(x_mem[b]);
      dy  = longint'(y_mem[a]) - longint'(y_mem[b]);
      lim = longint'(join_distance_cfg);
      return (dx * dx + dy * dy) <= (lim * lim);
   endfunction

   // breadth-first labeling in index order
   function automatic int label_clusters();
      int search [MAX_POINTS];
      int head;
      int tail;
      int cur;
      int clusters;
      clusters = 0;
      foreach (label_mem[k]) label_mem[k] = '0;
      for (int i = 0; i < point_total; i++) begin
         if (label_mem[i] == '0) begin
            clusters++;
            label_mem[i] = ANS_BITS'(clusters);
            search[0] = i;
            head = 0;
            tail = 1;
            while (head < tail) begin
               cur = search[head];
               head++;
               for (int v = 0; v < point_total; v++) begin
                  if (v != cur && label_mem[v] == '0 && in_reach(cur, v)) begin
                     label_mem[v] = ANS_BITS'(clusters);
                     search[tail] = v;
                     tail++;
                  end
               end
            end
         end
      end
      return clusters;
   endfunction

   function automatic labeler_result_t labeler_response(labeler_item_t it);
      labeler_result_t res;
      res = '0;
      case (it.op)
         OP_LOAD: begin
            if (point_total >= MAX_POINTS) begin
               res.error = 1'b1;
            end else begin
               x_mem[point_total]     = it.point_x[COORD_BITS-1:0];
               y_mem[point_total]     = it.point_y[COORD_BITS-1:0];
               label_mem[point_total] = '0;
               point_total++;
            end
         end
         OP_RUN: begin
            res.answer = ANS_BITS'(label_clusters());
         end
         OP_QUERY: begin
            if (int'(it.query_index) >= point_total) res.error = 1'b1;
            else res.answer = label_mem[it.query_index];
         end
         default: begin
            point_total = 0;
            foreach (label_mem[k]) label_mem[k] = '0;
         end
      endcase
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.op          <= OP_LOAD;
         req_bus.point_x     <= '0;
         req_bus.point_y     <= '0;
         req_bus.query_index <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            rsp_expected.push_back(labeler_response(item_on_bus));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               item_on_bus = req_backlog.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.op          <= item_on_bus.op;
               req_bus.point_x     <= item_on_bus.point_x;
               req_bus.point_y     <= item_on_bus.point_y;
               req_bus.query_index <= item_on_bus.query_index;
               if (!steady_tail && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 4);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      labeler_result_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_expected.size() == 0) begin
               $error("unexpected item: answer %0d error %0d", rsp_bus.answer, rsp_bus.error);
               fail_count++;
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_bus.answer !== want.answer) begin
                  $error("answer mismatch: expected %0d, actual %0d", want.answer, rsp_bus.answer);
                  fail_count++;
               end
               if (rsp_bus.error !== want.error) begin
                  $error("error mismatch: expected %0d, actual %0d", want.error, rsp_bus.error);
                  fail_count++;
               end
            end
         end
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off while requests keep coming
   initial begin
      while (!stall_request) @(posedge clock);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void add_item(tgcl_op_type op, int px, int py, int qi);
      labeler_item_t it;
      it.op          = op;
      it.point_x     = FIELD_BITS'(px);
      it.point_y     = FIELD_BITS'(py);
      it.query_index = QIDX_BITS'(qi);
      req_backlog.push_back(it);
      items_queued++;
   endfunction

   function automatic void add_plain(tgcl_op_type op, int qi);
      add_item(op, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), qi);
   endfunction

   function automatic int near_coord(int center, int span);
      int v;
      v = center + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   // points scattered around a few centers, then a run and queries
   function automatic void queue_cluster_phase(int pts, bit fresh, bit fill);
      int cx [4];
      int cy [4];
      int centers;
      int c;
      int span;
      int top_index;
      span = (join_distance_cfg > 600) ? 600 : int'(join_distance_cfg) + 1;
      if (fresh) add_plain(OP_CLEAR, $urandom_range(0, QIDX_MAX));
      centers = $urandom_range(1, 4);
      for (int k = 0; k < 4; k++) begin
         cx[k] = $urandom_range(0, COORD_MAX);
         cy[k] = $urandom_range(0, COORD_MAX);
      end
      for (int i = 0; i < pts; i++) begin
         c = $urandom_range(0, centers - 1);
         add_item(OP_LOAD, near_coord(cx[c], span), near_coord(cy[c], span),
                  $urandom_range(0, QIDX_MAX));
         if (!fill && $urandom_range(0, 9) == 0) add_plain(OP_QUERY, $urandom_range(0, pts));
      end
      if (fill) repeat ($urandom_range(1, 2)) add_plain(OP_LOAD, $urandom_range(0, QIDX_MAX));
      add_plain(OP_RUN, $urandom_range(0, QIDX_MAX));
      top_index = fill ? QIDX_MAX : ((pts + 2 > QIDX_MAX) ? QIDX_MAX : pts + 2);
      repeat ($urandom_range(2, 8)) add_plain(OP_QUERY, $urandom_range(0, top_index));
      if (!fill && $urandom_range(0, 2) == 0) begin
         c = $urandom_range(0, centers - 1);
         add_item(OP_LOAD, near_coord(cx[c], span), near_coord(cy[c], span), 0);
         add_plain(OP_QUERY, pts);
         add_plain(OP_RUN, 0);
         repeat ($urandom_range(1, 3)) add_plain(OP_QUERY, $urandom_range(0, pts + 1));
      end
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 5)) begin
            add_plain(tgcl_op_type'($urandom_range(0, 3)), $urandom_range(0, QIDX_MAX));
         end
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_bus.valid || rsp_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_join_distance(input int value);
      @(posedge clock);
      csr_bus.valid         <= 1'b1;
      csr_bus.join_distance <= JD_BITS'(value);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid     <= 1'b0;
      join_distance_cfg = JD_BITS'(value);
   endtask

   initial begin
      int jd;
      int phase_num;
      bit fill;
      req_bus.valid         = 1'b0;
      req_bus.op            = OP_LOAD;
      req_bus.point_x       = '0;
      req_bus.point_y       = '0;
      req_bus.query_index   = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.join_distance = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // widest distance: corners chain along the edges
      write_join_distance(JD_MAX);
      add_plain(OP_QUERY, 0);
      add_plain(OP_RUN, 0);
      add_item(OP_LOAD, 0, 0, 0);
      add_item(OP_LOAD, COORD_MAX, 0, 0);
      add_item(OP_LOAD, COORD_MAX, COORD_MAX, 0);
      add_item(OP_LOAD, 0, COORD_MAX, 0);
      add_plain(OP_RUN, 0);
      for (int i = 0; i < 5; i++) add_plain(OP_QUERY, i);
      wait_drained();

      // zero distance: only duplicates join, late load stays unlabeled
      write_join_distance(0);
      add_item(OP_LOAD, 0, 0, 0);
      add_plain(OP_RUN, 0);
      add_plain(OP_QUERY, 4);
      add_item(OP_LOAD, 17, 17, 0);
      add_plain(OP_QUERY, 5);
      add_plain(OP_CLEAR, 0);
      add_plain(OP_QUERY, 0);
      wait_drained();

      // exact distance boundary
      write_join_distance(5);
      add_item(OP_LOAD, 100, 100, 0);
      add_item(OP_LOAD, 103, 104, 0);
      add_item(OP_LOAD, 106, 108, 0);
      add_item(OP_LOAD, 109, 113, 0);
      add_plain(OP_RUN, 0);
      add_plain(OP_QUERY, 2);
      add_plain(OP_QUERY, 3);
      add_plain(OP_QUERY, QIDX_MAX);
      wait_drained();

      phase_num = 0;
      while (items_queued < ITEM_TARGET) begin
         if (items_queued >= ITEM_TARGET - CALM_ITEMS) steady_tail = 1'b1;
         if (phase_num == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0:          jd = 0;
               1:          jd = JD_MAX;
               2:          jd = 1;
               3, 4, 5, 6: jd = $urandom_range(2, 200);
               default:    jd = $urandom_range(0, JD_MAX);
            endcase
            write_join_distance(jd);
         end
         fill = (phase_num == 3 || phase_num == 30 || phase_num == 60);
         if (fill) queue_cluster_phase(MAX_POINTS, 1'b1, 1'b1);
         else queue_cluster_phase($urandom_range(0, 12), $urandom_range(0, 5) != 0, 1'b0);
         if (phase_num == 30) stall_request = 1'b1;
         wait_drained();
         phase_num++;
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && rsp_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
